// ===== hw/rtl/irpf_pkg.sv =====
// Shared types, constants and functions of the item record packet framer.
`default_nettype none

package irpf_pkg;

    // Register indexes of the configuration port
    localparam logic [1:0] CFG_START_BYTE = 2'd0;
    localparam logic [1:0] CFG_END_BYTE   = 2'd1;
    localparam logic [1:0] CFG_ITEM_COUNT = 2'd2;

    localparam logic [7:0] RST_START_BYTE = 8'd2;
    localparam logic [7:0] RST_END_BYTE   = 8'd3;
    localparam logic [7:0] RST_ITEM_COUNT = 8'd5;

    localparam int DEF_MAX_ITEMS   = 255;
    localparam int DEF_QUEUE_DEPTH = 2;

    // Quality codes
    localparam logic [3:0] QC_GOOD      = 4'd0;
    localparam logic [3:0] QC_UNCERTAIN = 4'd1;
    localparam logic [3:0] QC_W08       = 4'd2;
    localparam logic [3:0] QC_W18       = 4'd3;
    localparam logic [3:0] QC_W0C       = 4'd4;
    localparam logic [3:0] QC_W10       = 4'd5;
    localparam logic [3:0] QC_OTHER     = 4'd9;

    // Byte slot within one item's byte sequence
    typedef enum logic [3:0] {
        BS_START = 4'd0,
        BS_LEN0  = 4'd1,
        BS_LEN1  = 4'd2,
        BS_COUNT = 4'd3,
        BS_ID0   = 4'd4,
        BS_ID1   = 4'd5,
        BS_QUAL  = 4'd6,
        BS_VAL0  = 4'd7,
        BS_VAL1  = 4'd8,
        BS_VAL2  = 4'd9,
        BS_VAL3  = 4'd10,
        BS_CSUM  = 4'd11,
        BS_END   = 4'd12
    } t_bsel;

    // Classified item as it travels from front to back
    typedef struct packed {
        logic        first;
        logic        last;
        logic [7:0]  count;
        logic [15:0] len;
        logic [15:0] id;
        logic [3:0]  qcode;
        logic [31:0] value;
    } t_entry;

    function automatic logic [3:0] f_qcode(input logic [15:0] q);
        logic [3:0] code;
        if (q[7:6] == 2'b11) begin
            code = QC_GOOD;
        end else if (q[7:6] == 2'b01) begin
            code = QC_UNCERTAIN;
        end else begin
            unique case (q)
                16'h0008: code = QC_W08;
                16'h0018: code = QC_W18;
                16'h000C: code = QC_W0C;
                16'h0010: code = QC_W10;
                default:  code = QC_OTHER;
            endcase
        end
        return code;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/irpf_fifo.sv =====
// Small register queue between the front and back parts of the framer.
`default_nettype none

module irpf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_full,
    output logic                  o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, n_wr;
    logic [AW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_count, n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue pop while empty");
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("queue count did not follow push");

endmodule

`default_nettype wire

// ===== hw/rtl/irpf_front.sv =====
// Front part: accepts items, tracks frame position and classifies each item.
`default_nettype none

module irpf_front #(
    parameter int MAX_ITEMS = 255
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic [7:0]      i_cfg_count,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire logic [15:0]     i_item_id,
    input  wire logic [15:0]     i_raw_quality,
    input  wire logic [31:0]     i_item_value,
    input  wire logic            i_q_full,
    output logic                 o_push,
    output irpf_pkg::t_entry     o_entry
);
    import irpf_pkg::*;

    logic [7:0]  r_done, n_done;
    logic [7:0]  eff_count;
    logic [8:0]  done_inc;
    logic        is_last;

    // zero is taken as one, anything above the limit is clamped
    always_comb begin
        if (i_cfg_count == 8'd0) begin
            eff_count = 8'd1;
        end else if (i_cfg_count > 8'(MAX_ITEMS)) begin
            eff_count = 8'(MAX_ITEMS);
        end else begin
            eff_count = i_cfg_count;
        end
    end

    assign done_inc   = {1'b0, r_done} + 9'd1;
    assign is_last    = (done_inc >= {1'b0, eff_count});
    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_comb begin
        o_entry.first = (r_done == 8'd0);
        o_entry.last  = is_last;
        o_entry.count = eff_count;
        // 1 + 7 * count
        o_entry.len   = 16'({eff_count, 3'b000}) - 16'(eff_count) + 16'd1;
        o_entry.id    = i_item_id;
        o_entry.qcode = f_qcode(i_raw_quality);
        o_entry.value = i_item_value;
    end

    always_comb begin
        n_done = r_done;
        if (o_push) begin
            n_done = is_last ? 8'd0 : done_inc[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 8'd0;
        end else begin
            r_done <= n_done;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/irpf_back.sv =====
// Back part: turns queued items into the framed byte stream with checksum.
`default_nettype none

module irpf_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic [7:0]      i_cfg_start,
    input  wire logic [7:0]      i_cfg_end,
    input  wire irpf_pkg::t_entry i_entry,
    input  wire logic            i_q_empty,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output logic [7:0]           o_out_byte,
    output logic                 o_frame_end
);
    import irpf_pkg::*;

    logic    r_busy, n_busy;
    t_bsel   r_idx, n_idx;
    logic [7:0] r_xor, n_xor;
    logic    r_ovalid, n_ovalid;
    t_entry  r_ent, n_ent;
    logic [7:0] r_obyte, n_obyte;
    logic    r_oend, n_oend;

    logic       load;
    logic       last_byte;
    logic [7:0] cur_byte;

    assign load      = !r_ovalid || i_out_ready;
    assign last_byte = (r_idx == BS_END) || ((r_idx == BS_VAL3) && !r_ent.last);

    always_comb begin
        unique case (r_idx)
            BS_START: cur_byte = i_cfg_start;
            BS_LEN0:  cur_byte = r_ent.len[7:0];
            BS_LEN1:  cur_byte = r_ent.len[15:8];
            BS_COUNT: cur_byte = r_ent.count;
            BS_ID0:   cur_byte = r_ent.id[7:0];
            BS_ID1:   cur_byte = r_ent.id[15:8];
            BS_QUAL:  cur_byte = {4'd0, r_ent.qcode};
            BS_VAL0:  cur_byte = r_ent.value[7:0];
            BS_VAL1:  cur_byte = r_ent.value[15:8];
            BS_VAL2:  cur_byte = r_ent.value[23:16];
            BS_VAL3:  cur_byte = r_ent.value[31:24];
            BS_CSUM:  cur_byte = r_xor;
            BS_END:   cur_byte = i_cfg_end;
            default:  cur_byte = 8'd0;
        endcase
    end

    always_comb begin
        n_busy   = r_busy;
        n_idx    = r_idx;
        n_xor    = r_xor;
        n_ovalid = r_ovalid;
        n_ent    = r_ent;
        n_obyte  = r_obyte;
        n_oend   = r_oend;
        o_pop    = 1'b0;

        if (load) begin
            n_ovalid = r_busy;
            if (r_busy) begin
                n_obyte = cur_byte;
                n_oend  = (r_idx == BS_END);
                unique case (r_idx)
                    BS_START, BS_END: n_xor = 8'd0;
                    BS_CSUM:          n_xor = r_xor;
                    default:          n_xor = r_xor ^ cur_byte;
                endcase
                if (last_byte) begin
                    n_busy = 1'b0;
                end else begin
                    n_idx = t_bsel'(r_idx + 4'd1);
                end
            end
        end

        // take the next item as soon as the current one hands out its last byte
        if (!i_q_empty && (!r_busy || (load && last_byte))) begin
            o_pop  = 1'b1;
            n_busy = 1'b1;
            n_ent  = i_entry;
            n_idx  = i_entry.first ? BS_START : BS_ID0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_idx    <= BS_START;
            r_xor    <= 8'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_idx    <= n_idx;
            r_xor    <= n_xor;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent   <= n_ent;
        r_obyte <= n_obyte;
        r_oend  <= n_oend;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_byte  = r_obyte;
    assign o_frame_end = r_oend;

    a_hdr_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && (r_idx == BS_START)) |-> r_ent.first)
        else $error("header slot on an item that does not open a frame");
    a_trl_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && (r_idx == BS_CSUM)) |-> r_ent.last)
        else $error("trailer slot on an item that does not close a frame");
    a_xor_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && r_busy && (r_idx == BS_END)) |=> (r_xor == 8'd0) && o_frame_end)
        else $error("checksum not cleared after end byte");

endmodule

`default_nettype wire

// ===== hw/rtl/item_record_packet_framer_core.sv =====
// Top level of the item record packet framer: config registers, front, queue, back.
`default_nettype none

// Each accepted item (id, raw quality word, signed value) becomes seven bytes:
// id little endian, a one-byte quality code, value little endian. The first
// item of a frame is preceded by the start byte, the 16-bit little-endian
// length (1 + 7 * count) and the count byte; the last item is followed by
// the XOR checksum of every byte after the start byte and by the end byte,
// which is flagged with o_frame_end. Bytes leave through an output register,
// one per cycle while the consumer is ready, so an item takes 7 output bytes,
// 11 when it opens a frame, 9 when it closes one and 13 when the count is one;
// the byte rate of the output port sets the throughput. The front accepts an
// item whenever the queue between front and back has room, so inputs keep
// flowing while the back is still sending or the consumer stalls. A count
// of zero is taken as one and counts above MAX_ITEMS are clamped. Register
// writes (index 0 start byte, 1 end byte, 2 item count, 3 ignored) take
// effect at once and are meant for idle periods only.
module item_record_packet_framer_core #(
    parameter int MAX_ITEMS   = irpf_pkg::DEF_MAX_ITEMS,
    parameter int QUEUE_DEPTH = irpf_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration write port
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [7:0]         i_cfg_data,
    // item input
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [15:0]        i_item_id,
    input  wire logic [15:0]        i_raw_quality,
    input  wire logic signed [31:0] i_item_value,
    // byte output
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [7:0]              o_out_byte,
    output logic                    o_frame_end
);
    import irpf_pkg::*;

    logic [7:0] r_start_byte;
    logic [7:0] r_end_byte;
    logic [7:0] r_item_count;

    logic   push;
    logic   pop;
    logic   q_full;
    logic   q_empty;
    t_entry fr_entry;
    t_entry bk_entry;
    logic [$bits(t_entry)-1:0] q_rdata;

    // Configuration registers; unknown index is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= RST_START_BYTE;
            r_end_byte   <= RST_END_BYTE;
            r_item_count <= RST_ITEM_COUNT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_START_BYTE: r_start_byte <= i_cfg_data;
                CFG_END_BYTE:   r_end_byte   <= i_cfg_data;
                CFG_ITEM_COUNT: r_item_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    irpf_front #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_count   (r_item_count),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_item_id     (i_item_id),
        .i_raw_quality (i_raw_quality),
        .i_item_value  (i_item_value),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_entry       (fr_entry)
    );

    irpf_fifo #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (fr_entry),
        .i_pop   (pop),
        .o_data  (q_rdata),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    assign bk_entry = t_entry'(q_rdata);

    irpf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_start (r_start_byte),
        .i_cfg_end   (r_end_byte),
        .i_entry     (bk_entry),
        .i_q_empty   (q_empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_frame_end (o_frame_end)
    );

endmodule

`default_nettype wire

// ===== verif/irpf_frame_checker.sv =====
// Checker for the item record packet framer: predicts every framed byte and compares it.
module irpf_frame_checker #(
    parameter int MAX_ITEMS = irpf_pkg::DEF_MAX_ITEMS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [7:0]         i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [15:0]        i_item_id,
    input  logic [15:0]        i_raw_quality,
    input  logic signed [31:0] i_item_value,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [7:0]         i_out_byte,
    input  logic               i_frame_end,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_bytes_checked,
    output int                 o_frames_closed
);
    import irpf_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_frame_byte;

    t_frame_byte expected_bytes[$];
    t_frame_byte head;

    // shadow registers and frame state
    logic [7:0] start_reg;
    logic [7:0] end_reg;
    logic [7:0] count_reg;
    logic [7:0] csum;
    logic [7:0] items_in_frame;

    int fail_count    = 0;
    int bytes_checked = 0;
    int frames_closed = 0;

    assign o_fail_count    = fail_count;
    assign o_bytes_checked = bytes_checked;
    assign o_frames_closed = frames_closed;

    function automatic logic [7:0] quality_byte(input logic [15:0] raw);
        logic [3:0] qc;
        case (raw[7:6])
            2'b11: qc = QC_GOOD;
            2'b01: qc = QC_UNCERTAIN;
            default: begin
                // only an exact whole-word match earns a specific code
                if (raw == 16'h0008)      qc = QC_W08;
                else if (raw == 16'h0018) qc = QC_W18;
                else if (raw == 16'h000C) qc = QC_W0C;
                else if (raw == 16'h0010) qc = QC_W10;
                else                      qc = QC_OTHER;
            end
        endcase
        return {4'h0, qc};
    endfunction

    task automatic emit(input logic [7:0] b, input logic last, input logic summed);
        expected_bytes.push_back('{data: b, last: last});
        if (summed) csum ^= b;
    endtask

    task automatic frame_item_bytes(input logic [15:0] id, input logic [15:0] raw,
                                    input logic [31:0] value);
        int          cnt;
        logic [15:0] len;
        cnt = (count_reg == 8'd0) ? 1 : int'(count_reg);
        if (cnt > MAX_ITEMS) cnt = MAX_ITEMS;
        len = 16'(1 + 7 * cnt);
        if (items_in_frame == 8'd0) begin
            csum = 8'h00;
            emit(start_reg, 1'b0, 1'b0);
            emit(len[7:0], 1'b0, 1'b1);
            emit(len[15:8], 1'b0, 1'b1);
            emit(8'(cnt), 1'b0, 1'b1);
        end
        emit(id[7:0], 1'b0, 1'b1);
        emit(id[15:8], 1'b0, 1'b1);
        emit(quality_byte(raw), 1'b0, 1'b1);
        emit(value[7:0], 1'b0, 1'b1);
        emit(value[15:8], 1'b0, 1'b1);
        emit(value[23:16], 1'b0, 1'b1);
        emit(value[31:24], 1'b0, 1'b1);
        // a count lowered mid-frame closes the frame at the next item
        if (int'(items_in_frame) + 1 >= cnt) begin
            emit(csum, 1'b0, 1'b0);
            emit(end_reg, 1'b1, 1'b0);
            items_in_frame = 8'd0;
            csum           = 8'h00;
            frames_closed++;
        end else begin
            items_in_frame = items_in_frame + 8'd1;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start_reg      = RST_START_BYTE;
            end_reg        = RST_END_BYTE;
            count_reg      = RST_ITEM_COUNT;
            csum           = 8'h00;
            items_in_frame = 8'd0;
            expected_bytes.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_START_BYTE: start_reg = i_cfg_data;
                    CFG_END_BYTE:   end_reg   = i_cfg_data;
                    CFG_ITEM_COUNT: count_reg = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_bytes.size() == 0) begin
                    $error("out_byte %h arrived with no byte expected", i_out_byte);
                    fail_count++;
                end else begin
                    head = expected_bytes.pop_front();
                    bytes_checked++;
                    if (i_out_byte !== head.data) begin
                        $error("out_byte mismatch: expected %h, actual %h",
                               head.data, i_out_byte);
                        fail_count++;
                    end
                    if (i_frame_end !== head.last) begin
                        $error("frame_end mismatch: expected %b, actual %b",
                               head.last, i_frame_end);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                frame_item_bytes(i_item_id, i_raw_quality, i_item_value);
            end
        end
        o_pending <= expected_bytes.size();
    end

endmodule

// ===== verif/tb.sv =====
// Testbench top for the item record packet framer: stimulus, receiver stalls and verdict.
module tb;
    import irpf_pkg::*;

    localparam int ITEMS_TARGET = 370;
    // the limit keeps a wide margin over the worst case of ~370 items x 13 bytes
    // at 1/8 ready duty plus gaps and long hold-offs
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 250;
    localparam int TAIL_CYCLES  = 20;
    // index with no register behind it; writes must be ignored
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               cfg_we      = 1'b0;
    logic [1:0]         cfg_idx     = CFG_START_BYTE;
    logic [7:0]         cfg_data    = 8'h00;
    logic               in_valid    = 1'b0;
    logic [15:0]        item_id     = 16'h0000;
    logic [15:0]        raw_quality = 16'h0000;
    logic signed [31:0] item_value  = 32'sh0;
    logic               out_ready   = 1'b0;
    wire                in_ready;
    wire                out_valid;
    wire  [7:0]         out_byte;
    wire                frame_end;

    int fail_count;
    int pending;
    int bytes_checked;
    int frames_closed;

    int         items_sent    = 0;
    int         settings_used = 0;
    int         burst_left    = 0;
    int         cycle_count   = 0;
    int         big_frames    = 0;
    logic [7:0] count_now     = RST_ITEM_COUNT;
    // each toggle asks the receiver for one long hold-off
    logic       stall_tog     = 1'b0;

    // receiver state
    logic       stall_seen = 1'b0;
    int         hold_left  = 0;
    int         pat_left   = 0;
    logic [7:0] pattern    = 8'hFF;

    always #6 clk = ~clk;

    item_record_packet_framer_core u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_item_id     (item_id),
        .i_raw_quality (raw_quality),
        .i_item_value  (item_value),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_out_byte    (out_byte),
        .o_frame_end   (frame_end)
    );

    irpf_frame_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_item_id       (item_id),
        .i_raw_quality   (raw_quality),
        .i_item_value    (item_value),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_out_byte      (out_byte),
        .i_frame_end     (frame_end),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_bytes_checked (bytes_checked),
        .o_frames_closed (frames_closed)
    );

    // Receiver: a rotating ready pattern that is reloaded after a random run
    // length (often all ones, so there are stretches without stalls), and a
    // long hold-off on request so the framer's queue fills and in_ready drops.
    always @(posedge clk) begin
        if (stall_tog != stall_seen) begin
            stall_seen = stall_tog;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            if (pat_left == 0) begin
                pattern  = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom);
                if (pattern == 8'h00) pattern = 8'h01;
                pat_left = $urandom_range(16, 96);
            end
            pat_left--;
            out_ready <= pattern[0];
            pattern = {pattern[0], pattern[7:1]};
        end
    end

    // Watchdog: a missing byte or a hung handshake ends up here.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles, %0d bytes outstanding",
                     cycle_count, pending);
            $display("Some tests failed");
            $finish;
        end
    end

    // One register write; the enable drops on the following edge, so
    // back-to-back calls never assign cfg_we twice in one step.
    task automatic cfg_write(input logic [1:0] idx, input logic [7:0] data);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we   <= 1'b0;
        if (idx == CFG_ITEM_COUNT) count_now = data;
    endtask

    // Offer one item; bursts of random length are separated by random gaps,
    // and valid stays up between items of the same burst.
    task automatic send_item(input logic [15:0] id, input logic [15:0] q,
                             input logic [31:0] v);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 5) == 0) ? 64 : $urandom_range(1, 16);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid    <= 1'b1;
        item_id     <= id;
        raw_quality <= q;
        item_value  <= v;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    // Close a phase: stop offering and wait until every predicted byte has
    // been seen, so the block is idle for the next register writes.
    task automatic end_phase();
        in_valid <= 1'b0;
        settings_used++;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    function automatic logic [15:0] random_quality();
        logic [15:0] w;
        w = 16'($urandom);
        case ($urandom_range(0, 7))
            0: w[7:6] = 2'b11;
            1: w[7:6] = 2'b01;
            2, 3: begin
                case ($urandom_range(0, 3))
                    0:       w = 16'h0008;
                    1:       w = 16'h0018;
                    2:       w = 16'h000C;
                    default: w = 16'h0010;
                endcase
            end
            4: w[7:6] = {1'($urandom_range(0, 1)), 1'b0};
            // low words near the exact matches
            5: w = {10'h000, w[5:0]};
            default: ;
        endcase
        return w;
    endfunction

    function automatic logic [31:0] random_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return 32'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] random_marker();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_random_item();
        logic [15:0] id;
        id = ($urandom_range(0, 9) == 0) ? {16{1'($urandom_range(0, 1))}}
                                         : 16'($urandom);
        send_item(id, random_quality(), random_value());
    endtask

    initial begin
        int eff;
        int n;
        int sel;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: one full frame of five items covering field
        // extremes, the good and uncertain classes and three exact words.
        send_item(16'h0000, 16'h00C0, 32'h8000_0000);
        send_item(16'hFFFF, 16'h0040, 32'h7FFF_FFFF);
        send_item(16'h1234, 16'h0008, 32'hFFFF_FFFF);
        send_item(16'h8001, 16'h0018, 32'h0000_0000);
        send_item(16'h00FF, 16'h000C, 32'h0102_0304);
        end_phase();

        // One item per frame, extreme markers: every item opens and closes.
        cfg_write(CFG_START_BYTE, 8'h00);
        cfg_write(CFG_END_BYTE, 8'hFF);
        cfg_write(CFG_ITEM_COUNT, 8'd1);
        send_item(16'hA55A, 16'h0010, 32'h5A5A_A5A5);
        send_item(16'h5AA5, 16'h0000, 32'hA5A5_5A5A);
        send_item(16'hFF00, 16'hFFFF, 32'h00FF_00FF);
        // bits 7:6 clear but not an exact word
        send_item(16'h00FF, 16'h0108, 32'hFF00_FF00);
        end_phase();

        // Count zero is taken as one; markers swapped.
        cfg_write(CFG_START_BYTE, 8'hFF);
        cfg_write(CFG_END_BYTE, 8'h00);
        cfg_write(CFG_ITEM_COUNT, 8'd0);
        send_item(16'h0001, 16'h0080, 32'h0000_0001);
        send_item(16'h8000, 16'hFF7F, 32'hFFFF_FFFE);
        end_phase();

        // Write to the unused index, then leave a two-item frame half open.
        cfg_write(CFG_UNUSED, 8'hA5);
        cfg_write(CFG_ITEM_COUNT, 8'd2);
        send_item(16'h4242, 16'h00FF, 32'h1234_5678);
        send_item(16'h2424, 16'h0018, 32'h8765_4321);
        send_item(16'h3C3C, 16'h000C, 32'hCAFE_F00D);
        end_phase();

        // Count lowered below the items already sent: the next item closes.
        cfg_write(CFG_ITEM_COUNT, 8'd1);
        send_item(16'hC3C3, 16'h0010, 32'h0BAD_F00D);
        end_phase();

        // Largest count with a long receiver hold-off while the sender
        // keeps offering; this frame may then be cut short by the next phase.
        cfg_write(CFG_ITEM_COUNT, 8'd255);
        stall_tog <= ~stall_tog;
        big_frames++;
        repeat (40) send_random_item();
        end_phase();

        // Random phases: new settings on most phases, mostly whole frames.
        while (items_sent < ITEMS_TARGET) begin
            if ($urandom_range(0, 2) == 0) cfg_write(CFG_START_BYTE, random_marker());
            if ($urandom_range(0, 2) == 0) cfg_write(CFG_END_BYTE, random_marker());
            if ($urandom_range(0, 7) == 0) cfg_write(CFG_UNUSED, 8'($urandom));
            if ($urandom_range(0, 3) != 0) begin
                sel = $urandom_range(0, 19);
                if (sel == 0) begin
                    cfg_write(CFG_ITEM_COUNT, 8'd0);
                end else if (sel == 1 && big_frames < 2) begin
                    cfg_write(CFG_ITEM_COUNT, 8'd255);
                    big_frames++;
                end else if (sel < 14) begin
                    cfg_write(CFG_ITEM_COUNT, 8'($urandom_range(1, 6)));
                end else begin
                    cfg_write(CFG_ITEM_COUNT, 8'($urandom_range(7, 20)));
                end
            end
            eff = (count_now == 8'd0) ? 1 : int'(count_now);
            if (eff > 20) begin
                n = $urandom_range(10, 30);
            end else if ($urandom_range(0, 3) != 0) begin
                n = eff * $urandom_range(1, (24 / eff > 1) ? 24 / eff : 1);
            end else begin
                n = $urandom_range(1, 15);
            end
            if ($urandom_range(0, 5) == 0) stall_tog <= ~stall_tog;
            repeat (n) send_random_item();
            end_phase();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Covered %0d items over %0d register settings (counts 0, 1, 2..20, 255).",
                 items_sent, settings_used);
        $display("Compared %0d bytes in %0d closed frames.", bytes_checked, frames_closed);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/irpf_pkg.sv
hw/rtl/irpf_fifo.sv
hw/rtl/irpf_front.sv
hw/rtl/irpf_back.sv
hw/rtl/item_record_packet_framer_core.sv
verif/irpf_frame_checker.sv
verif/tb.sv
